// ----- sv/zpfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_pkg: shared definitions for the zero-padded FIR smoother
// Widths, register indexes, reset values and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package zpfs_pkg;

	localparam int MAX_HALF_WIDTH = 3;
	localparam int SAMPLE_BITS    = 16;
	localparam int NTAPS          = 2 * MAX_HALF_WIDTH + 1;
	localparam int TAP_W          = $clog2(NTAPS);
	localparam int POS_W          = TAP_W + 1;
	localparam int LAG_W          = $clog2(MAX_HALF_WIDTH + 1);
	localparam int SEEN_W         = $clog2(MAX_HALF_WIDTH + 2);
	localparam int COEF_W         = 16;
	localparam int HW_W           = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int PROD_W         = SAMPLE_BITS + COEF_W + 1;
	localparam int ACC_W          = PROD_W + TAP_W;
	localparam int RND_SHIFT      = 15;
	localparam int Q_W            = ACC_W - RND_SHIFT;
	localparam int SAMPLE_MAX     = (1 << (SAMPLE_BITS - 1)) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd7;

	localparam logic [HW_W-1:0] HALF_WIDTH_RESET = 2'd1;

	// The coefficient registers cover offsets -3..+3 around the center.
	localparam int REG_TAPS   = 7;
	localparam int REG_CENTER = 3;
	localparam logic [COEF_W-1:0] COEF_INIT [REG_TAPS] =
		'{16'd0, 16'd0, 16'd10923, 16'd10922, 16'd10923, 16'd0, 16'd0};

	function automatic logic [COEF_W-1:0] coef_reset(input int tap);
		int j;
		j = tap - MAX_HALF_WIDTH + REG_CENTER;
		if (j >= 0 && j < REG_TAPS) begin
			return COEF_INIT[j];
		end
		return '0;
	endfunction

	typedef struct packed {
		logic             shift;
		logic             clear_win;
		logic             acc_clr;
		logic             mul_en;
		logic             pos_ok;
		logic [TAP_W-1:0] pos;
		logic [TAP_W-1:0] cidx;
	} zpfs_cmd_t;

	typedef struct packed {
		logic [LAG_W-1:0] half;
	} zpfs_sts_t;

endpackage

// ----- sv/zero_padded_fir_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_padded_fir_smoother: centered odd-length FIR smoother
// Zero-padded edges, Q3.12 samples, unsigned Q1.15 weights, outputs rounded
// half up and saturated.
//
// Channel   Handshake             Payload
// in        in_valid / in_stall   sample, last
// out       out_valid / out_stall smoothed, final_res
// cfg       cfg_wr_en             cfg_index, cfg_data
//
// A beat that yields no output leaves in_stall low. Each output steps its
// taps through the single shared multiplier and the accumulator, then waits
// out any stall of the out channel. A last beat yields up to M+1 outputs
// back to back in this way. After a beat that yields an output, in_stall
// is high until the last output is taken.
// Reset puts M at 1, loads the default weights and clears the window.
// ----------------------------------------------------------------------------
module zero_padded_fir_smoother (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr_en,
	input  logic [zpfs_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [zpfs_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [zpfs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                    last,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [zpfs_pkg::SAMPLE_BITS-1:0] smoothed,
	output logic                                    final_res
);

	zpfs_pkg::zpfs_cmd_t cmd;
	zpfs_pkg::zpfs_sts_t sts;

	zpfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.final_res (final_res),
		.sts       (sts),
		.cmd       (cmd)
	);

	zpfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.cmd       (cmd),
		.sts       (sts),
		.smoothed  (smoothed)
	);

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while an output beat is pending");

	a_final_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		final_res |-> out_valid)
		else $error("final flag raised without an output beat");

	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid)
		else $error("output beat appeared right after an input beat");

	a_shift_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (in_valid && !in_stall))
		else $error("window shifted without an input beat");

endmodule

// ----- sv/zpfs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_dp: smoother datapath
// Configuration registers, sample window, one multiplier with a product
// register, the accumulator, and rounding with saturation.
// ----------------------------------------------------------------------------
module zpfs_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [zpfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [zpfs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic signed [zpfs_pkg::SAMPLE_BITS-1:0] sample,
	input  zpfs_pkg::zpfs_cmd_t                  cmd,
	output zpfs_pkg::zpfs_sts_t                  sts,
	output logic signed [zpfs_pkg::SAMPLE_BITS-1:0] smoothed
);

	localparam logic signed [zpfs_pkg::Q_W-1:0] QHI = zpfs_pkg::Q_W'(zpfs_pkg::SAMPLE_MAX);
	localparam logic signed [zpfs_pkg::Q_W-1:0] QLO = -QHI - 1;

	logic [zpfs_pkg::HW_W-1:0]                hw_q;
	logic [zpfs_pkg::COEF_W-1:0]              coef_q [zpfs_pkg::NTAPS];
	logic signed [zpfs_pkg::SAMPLE_BITS-1:0]  win_q  [zpfs_pkg::NTAPS];
	logic signed [zpfs_pkg::PROD_W-1:0]       prod_s1;
	logic                                     prod_vld_s1;
	logic signed [zpfs_pkg::ACC_W-1:0]        acc_q;
	logic signed [zpfs_pkg::ACC_W-1:0]        rnd;
	logic signed [zpfs_pkg::Q_W-1:0]          q;
	logic                                     coef_sel;
	int                                       cfg_tap;

	assign coef_sel = cfg_wr_en && (cfg_index >= zpfs_pkg::REG_COEF_FIRST)
		&& (cfg_index <= zpfs_pkg::REG_COEF_LAST);
	assign cfg_tap = int'(cfg_index) - int'(zpfs_pkg::REG_COEF_FIRST)
		- zpfs_pkg::REG_CENTER + zpfs_pkg::MAX_HALF_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= zpfs_pkg::HALF_WIDTH_RESET;
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				coef_q[i] <= zpfs_pkg::coef_reset(i);
			end
		end else begin
			if (cfg_wr_en && cfg_index == zpfs_pkg::REG_HALF_WIDTH) begin
				hw_q <= cfg_data[zpfs_pkg::HW_W-1:0];
			end
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				if (coef_sel && cfg_tap == i) begin
					coef_q[i] <= cfg_data[zpfs_pkg::COEF_W-1:0];
				end
			end
		end
	end

	assign sts.half = (int'(hw_q) > zpfs_pkg::MAX_HALF_WIDTH)
		? zpfs_pkg::LAG_W'(zpfs_pkg::MAX_HALF_WIDTH) : zpfs_pkg::LAG_W'(hw_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.clear_win) begin
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.shift) begin
			win_q[0] <= sample;
			for (int i = 1; i < zpfs_pkg::NTAPS; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_ok) begin
			prod_s1 <= win_q[cmd.pos] * $signed({1'b0, coef_q[cmd.cidx]});
		end else begin
			prod_s1 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
		end else begin
			prod_vld_s1 <= cmd.mul_en;
			if (cmd.acc_clr) begin
				acc_q <= '0;
			end else if (prod_vld_s1) begin
				acc_q <= acc_q + zpfs_pkg::ACC_W'(prod_s1);
			end
		end
	end

	// Round half up, then floor by the arithmetic shift, then saturate.
	assign rnd = acc_q + zpfs_pkg::ACC_W'(1 << (zpfs_pkg::RND_SHIFT - 1));
	assign q   = rnd[zpfs_pkg::ACC_W-1:zpfs_pkg::RND_SHIFT];

	always_comb begin
		if (q > QHI) begin
			smoothed = zpfs_pkg::SAMPLE_BITS'(QHI);
		end else if (q < QLO) begin
			smoothed = zpfs_pkg::SAMPLE_BITS'(QLO);
		end else begin
			smoothed = q[zpfs_pkg::SAMPLE_BITS-1:0];
		end
	end

endmodule

// ----- sv/zpfs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpfs_ctrl: smoother controller
// Tracks the position in the signal, steps the multiply-accumulate over the
// taps of each output and walks the pending outputs on a flush.
// ----------------------------------------------------------------------------
module zpfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                final_res,
	input  zpfs_pkg::zpfs_sts_t sts,
	output zpfs_pkg::zpfs_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t                      state_q, state_d;
	logic [zpfs_pkg::SEEN_W-1:0] seen_q, seen_d;
	logic [zpfs_pkg::LAG_W-1:0]  lag_q, lag_d;
	logic [zpfs_pkg::TAP_W-1:0]  j_q, j_d;
	logic                        flush_q, flush_d;
	logic [zpfs_pkg::POS_W-1:0]  pos;
	logic [zpfs_pkg::POS_W-1:0]  cidx;
	logic [zpfs_pkg::POS_W-1:0]  span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			lag_q   <= '0;
			j_q     <= '0;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seen_q  <= seen_d;
			lag_q   <= lag_d;
			j_q     <= j_d;
			flush_q <= flush_d;
		end
	end

	// Tap j covers offset j - M, read from window position lag + M - j.
	assign pos  = zpfs_pkg::POS_W'(lag_q) + zpfs_pkg::POS_W'(sts.half)
		- zpfs_pkg::POS_W'(j_q);
	assign cidx = zpfs_pkg::POS_W'(j_q) + zpfs_pkg::POS_W'(zpfs_pkg::MAX_HALF_WIDTH)
		- zpfs_pkg::POS_W'(sts.half);
	assign span = {zpfs_pkg::POS_W'(sts.half)} << 1;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign final_res = out_valid && flush_q && (lag_q == '0);

	always_comb begin
		state_d       = state_q;
		seen_d        = seen_q;
		lag_d         = lag_q;
		j_d           = j_q;
		flush_d       = flush_q;
		cmd.shift     = 1'b0;
		cmd.clear_win = 1'b0;
		cmd.acc_clr   = 1'b0;
		cmd.mul_en    = 1'b0;
		cmd.pos_ok    = 1'b0;
		cmd.pos       = pos[zpfs_pkg::TAP_W-1:0];
		cmd.cidx      = cidx[zpfs_pkg::TAP_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.shift = 1'b1;
					if (int'(seen_q) < zpfs_pkg::MAX_HALF_WIDTH + 1) begin
						seen_d = seen_q + 1'b1;
					end
					j_d = '0;
					if (last) begin
						flush_d     = 1'b1;
						lag_d       = (int'(seen_q) < int'(sts.half))
							? zpfs_pkg::LAG_W'(seen_q) : sts.half;
						cmd.acc_clr = 1'b1;
						state_d     = ST_MAC;
					end else if (int'(seen_q) >= int'(sts.half)) begin
						flush_d     = 1'b0;
						lag_d       = sts.half;
						cmd.acc_clr = 1'b1;
						state_d     = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mul_en = 1'b1;
				cmd.pos_ok = !pos[zpfs_pkg::POS_W-1];
				if (zpfs_pkg::POS_W'(j_q) == span) begin
					state_d = ST_DRAIN;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					if (flush_q && lag_q != '0) begin
						lag_d       = lag_q - 1'b1;
						j_d         = '0;
						cmd.acc_clr = 1'b1;
						state_d     = ST_MAC;
					end else if (flush_q) begin
						cmd.clear_win = 1'b1;
						seen_d        = '0;
						flush_d       = 1'b0;
						state_d       = ST_IDLE;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- dv/zero_padded_fir_smoother_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_padded_fir_smoother_tb: self-checking testbench for the FIR smoother
// Drives sample beats and register writes and predicts every smoothed beat
// from a local copy of the window, the count and the weights. Each output
// beat is compared in order with the oldest prediction. Directed signals
// come first. Random signals under several weight and width settings follow,
// and a long output hold-off closes the run. Both channels idle at random.
// ----------------------------------------------------------------------------
module zero_padded_fir_smoother_tb;

	localparam int LIMIT_CYCLES = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 2 * (2 * zpfs_pkg::MAX_HALF_WIDTH + 3);

	typedef struct packed {
		logic signed [zpfs_pkg::SAMPLE_BITS-1:0] smoothed;
		logic                                    final_res;
	} smooth_beat_t;

	logic                                    clk       = 1'b0;
	logic                                    arst_n    = 1'b0;
	logic                                    cfg_wr_en = 1'b0;
	logic [zpfs_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
	logic [zpfs_pkg::CFG_DATA_W-1:0]         cfg_data  = '0;
	logic                                    in_valid  = 1'b0;
	logic signed [zpfs_pkg::SAMPLE_BITS-1:0] sample    = '0;
	logic                                    last      = 1'b0;
	logic                                    out_stall = 1'b0;
	logic                                    in_stall;
	logic                                    out_valid;
	logic signed [zpfs_pkg::SAMPLE_BITS-1:0] smoothed;
	logic                                    final_res;

	logic [zpfs_pkg::HW_W-1:0]               hw_q;
	logic [zpfs_pkg::COEF_W-1:0]             coef_q [zpfs_pkg::NTAPS];
	logic [zpfs_pkg::COEF_W-1:0]             staged_coefs [zpfs_pkg::NTAPS];
	logic signed [zpfs_pkg::SAMPLE_BITS-1:0] win_q [zpfs_pkg::NTAPS];
	int                                      seen_q;
	smooth_beat_t                            pending_smoothed [$];
	int                                      mismatches   = 0;
	int                                      cycles       = 0;
	bit                                      gaps_on      = 1'b0;
	bit                                      stall_on     = 1'b0;
	bit                                      hold_pending = 1'b0;

	always #2 clk = ~clk;

	zero_padded_fir_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.smoothed  (smoothed),
		.final_res (final_res)
	);

	function automatic logic signed [zpfs_pkg::SAMPLE_BITS-1:0] window_sum(input int m,
		input int lag);
		longint acc;
		int     pos;
		acc = 0;
		for (int d = -m; d <= m; d++) begin
			pos = lag - d;
			if (pos >= 0 && pos < zpfs_pkg::NTAPS) begin
				acc += longint'(win_q[pos])
					* longint'(coef_q[d + zpfs_pkg::MAX_HALF_WIDTH]);
			end
		end
		acc = (acc + 16384) >>> 15;
		if (acc > zpfs_pkg::SAMPLE_MAX) begin
			acc = zpfs_pkg::SAMPLE_MAX;
		end
		if (acc < -zpfs_pkg::SAMPLE_MAX - 1) begin
			acc = -zpfs_pkg::SAMPLE_MAX - 1;
		end
		return zpfs_pkg::SAMPLE_BITS'(acc);
	endfunction

	function automatic void predict_smoothed(
		input logic signed [zpfs_pkg::SAMPLE_BITS-1:0] s, input logic l);
		int           m;
		int           pos_idx;
		int           lag;
		smooth_beat_t b;
		m = int'(hw_q);
		if (m > zpfs_pkg::MAX_HALF_WIDTH) begin
			m = zpfs_pkg::MAX_HALF_WIDTH;
		end
		pos_idx = seen_q;
		for (int i = zpfs_pkg::NTAPS - 1; i > 0; i--) begin
			win_q[i] = win_q[i-1];
		end
		win_q[0] = s;
		if (seen_q < zpfs_pkg::MAX_HALF_WIDTH + 1) begin
			seen_q++;
		end
		if (!l) begin
			if (pos_idx >= m) begin
				b.smoothed  = window_sum(m, m);
				b.final_res = 1'b0;
				pending_smoothed.insert(pending_smoothed.size(), b);
			end
		end else begin
			lag = (pos_idx < m) ? pos_idx : m;
			for (int k = lag; k >= 0; k--) begin
				b.smoothed  = window_sum(m, k);
				b.final_res = (k == 0);
				pending_smoothed.insert(pending_smoothed.size(), b);
			end
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				win_q[i] = '0;
			end
			seen_q = 0;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic check_smoothed();
		smooth_beat_t b;
		if (pending_smoothed.size() == 0) begin
			report_mismatch($sformatf("output beat %0d/%0d with nothing expected",
				smoothed, final_res));
		end else begin
			b = pending_smoothed.pop_front();
			if (smoothed !== b.smoothed) begin
				report_mismatch($sformatf("smoothed %0d, expected %0d", smoothed, b.smoothed));
			end
			if (final_res !== b.final_res) begin
				report_mismatch($sformatf("final_res %b, expected %b", final_res, b.final_res));
			end
		end
	endtask

	// Both channels are observed here, inputs first, so the order of
	// processes within a time step does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_smoothed(sample, last);
			end
			if (out_valid && !out_stall) begin
				check_smoothed();
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_on && $urandom_range(0, 99) < 25) begin
				out_stall <= 1'b1;
				if ($urandom_range(0, 99) < 90) begin
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [zpfs_pkg::SAMPLE_BITS-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			return zpfs_pkg::SAMPLE_BITS'(zpfs_pkg::SAMPLE_MAX);
		end
		if (r < 12) begin
			return zpfs_pkg::SAMPLE_BITS'(-zpfs_pkg::SAMPLE_MAX - 1);
		end
		if (r < 30) begin
			return zpfs_pkg::SAMPLE_BITS'(int'($urandom_range(0, 128)) - 64);
		end
		return zpfs_pkg::SAMPLE_BITS'($urandom);
	endfunction

	task automatic send_sample(input logic signed [zpfs_pkg::SAMPLE_BITS-1:0] s,
		input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		last     <= l;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	task automatic send_signal(input int len);
		for (int k = 0; k < len; k++) begin
			send_sample(rand_sample(), k == len - 1);
		end
	endtask

	// Weights and width may only change with the block idle, so the output
	// queue has to be empty and a no-output beat must have had time to finish.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_smoothed.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [zpfs_pkg::CFG_DATA_W-1:0] hw_word);
		cfg_wr_en <= 1'b1;
		cfg_index <= zpfs_pkg::REG_HALF_WIDTH;
		cfg_data  <= hw_word;
		@(posedge clk);
		hw_q = hw_word[zpfs_pkg::HW_W-1:0];
		for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
			cfg_index <= zpfs_pkg::REG_COEF_FIRST + zpfs_pkg::CFG_IDX_W'(i);
			cfg_data  <= staged_coefs[i];
			@(posedge clk);
			coef_q[i] = staged_coefs[i];
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		send_sample(16'sd4096, 1'b1);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd1, 1'b1);
		settle_idle();
	endtask

	// Weights above one with the widest window drive the sum into saturation;
	// the short signals end before any non-flush output, so every output is a flush.
	task automatic test_edge_weights();
		for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
			staged_coefs[i] = 16'hFFFF;
		end
		load_config(16'd3);
		gaps_on  = 1'b1;
		stall_on = 1'b1;
		for (int k = 0; k < 4; k++) begin
			send_sample(16'sd32767, k == 3);
		end
		send_sample(-16'sd32768, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd12345, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		settle_idle();
	endtask

	// A single tap of one half shows rounding half up on both signs.
	task automatic test_rounding();
		for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
			staged_coefs[i] = '0;
		end
		staged_coefs[zpfs_pkg::MAX_HALF_WIDTH] = 16'd16384;
		load_config(16'hFFFC);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd3, 1'b0);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		settle_idle();
	endtask

	task automatic test_random_phases();
		int m;
		int r;
		int sent;
		int len;
		for (int p = 0; p < 7; p++) begin
			if (p == 0) begin
				m = 0;
			end else if (p == 1) begin
				m = zpfs_pkg::MAX_HALF_WIDTH;
			end else begin
				m = $urandom_range(0, zpfs_pkg::MAX_HALF_WIDTH);
			end
			for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
				r = $urandom_range(0, 9);
				case (r) inside
					0: begin
						staged_coefs[i] = '0;
					end
					1: begin
						staged_coefs[i] = 16'd32768;
					end
					2: begin
						staged_coefs[i] = 16'hFFFF;
					end
					[3:6]: begin
						staged_coefs[i] = zpfs_pkg::COEF_W'($urandom_range(0, 32768));
					end
					default: begin
						staged_coefs[i] = zpfs_pkg::COEF_W'($urandom);
					end
				endcase
			end
			load_config({(zpfs_pkg::CFG_DATA_W - zpfs_pkg::HW_W)'($urandom),
				zpfs_pkg::HW_W'(m)});
			sent = 0;
			while (sent < 46) begin
				gaps_on  = (p != 0) && ($urandom_range(0, 3) != 0);
				stall_on = (p != 0) && ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 20) begin
					len = $urandom_range(1, 3);
				end else if (r < 90) begin
					len = $urandom_range(4, 12);
				end else begin
					len = $urandom_range(13, 30);
				end
				send_signal(len);
				sent += len;
			end
			settle_idle();
		end
	endtask

	// The output side holds off for a long time while beats keep coming,
	// so the block fills up and has to stall its input.
	task automatic test_backpressure();
		for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
			staged_coefs[i] = zpfs_pkg::COEF_W'($urandom_range(0, 32768));
		end
		load_config(16'd2);
		gaps_on      = 1'b0;
		stall_on     = 1'b1;
		hold_pending = 1'b1;
		send_signal(10);
		send_signal(12);
		send_signal(8);
		settle_idle();
	endtask

	initial begin
		hw_q   = zpfs_pkg::HALF_WIDTH_RESET;
		seen_q = 0;
		for (int i = 0; i < zpfs_pkg::NTAPS; i++) begin
			coef_q[i] = zpfs_pkg::COEF_INIT[i];
			win_q[i]  = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_edge_weights();
		test_rounding();
		test_random_phases();
		test_backpressure();
		settle_idle();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
